// ===== design/dgr_pkg.sv =====
// shared types, constants and the gamma code function of the delta gamma run-length coder
package dgr_pkg;

    localparam logic [7:0] FRAME_LENGTH = 8'd128;
    localparam logic [1:0] RUN_PREFIX   = 2'b10;
    localparam logic [7:0] BYTE_MAX     = 8'hff;

    localparam int DATA_W      = 40;
    localparam int ACC_W       = 42;
    localparam int MAX_BYTES   = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_RAW   = 1'b0;
    localparam logic MODE_CODER = 1'b1;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CLOSE  = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [2:0]        count;
    } dgr_entry_t;

    typedef struct packed {
        logic       valid;
        dgr_entry_t entry;
    } dgr_push_t;

    typedef struct packed {
        logic [15:0] code;
        logic [4:0]  len;
    } dgr_gamma_t;

    function automatic dgr_gamma_t gamma_code(input logic [7:0] v);
        logic [3:0]  n;
        logic [15:0] ones;
        dgr_gamma_t  g;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i])
            begin
                n = 4'(i + 1);
            end
        end
        if (n == 4'd0)
        begin
            g.code = 16'd0;
            g.len  = 5'd1;
        end
        else
        begin
            ones   = (16'd1 << n) - 16'd1;
            g.code = (ones << n) | ({8'd0, v} ^ (16'd1 << (n - 4'd1)));
            g.len  = {n, 1'b0};
        end
        return g;
    endfunction

endpackage

// ===== design/dgr_front.sv =====
// front part: accepts items, runs the delta and run coder and packs bits into byte groups
module dgr_front
    import dgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       codec_mode,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] sample,
    input  logic       queue_full,
    output dgr_push_t  push
);

    logic [7:0] prev_sample_reg, prev_sample_next;
    logic [8:0] last_diff_reg, last_diff_next;
    logic [7:0] repeat_count_reg, repeat_count_next;
    logic [6:0] pending_bits_reg, pending_bits_next;
    logic [2:0] pending_cnt_reg, pending_cnt_next;
    logic [7:0] frame_pos_reg, frame_pos_next;

    logic             accept;
    logic [8:0]       diff;
    logic [8:0]       neg_diff;
    logic             is_neg;
    logic [7:0]       mag;
    logic             same;
    logic [7:0]       repeat_inc;
    logic [8:0]       frame_inc;
    logic             frame_end;
    logic [7:0]       run_count;
    dgr_gamma_t       run_gamma;
    dgr_gamma_t       diff_gamma;
    logic [17:0]      run_val;
    logic [4:0]       run_len;
    logic [16:0]      diff_val;
    logic [4:0]       diff_len;
    logic             emit_diff;
    logic [ACC_W-1:0] acc_a;
    logic [ACC_W-1:0] acc_b;
    logic [ACC_W-1:0] acc_out;
    logic [5:0]       total;
    logic [2:0]       rem;
    logic             pad;
    dgr_entry_t       entry;

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;

    assign diff     = {1'b0, sample} - {1'b0, prev_sample_reg};
    assign neg_diff = 9'd0 - diff;
    assign is_neg   = diff[8];
    assign mag      = is_neg ? neg_diff[7:0] : diff[7:0];
    assign same     = (diff == last_diff_reg);

    assign repeat_inc = (repeat_count_reg == BYTE_MAX) ? repeat_count_reg
                                                       : repeat_count_reg + 8'd1;
    assign frame_inc  = {1'b0, frame_pos_reg} + 9'd1;
    assign frame_end  = (frame_inc >= {1'b0, FRAME_LENGTH});

    assign emit_diff = (func == FUNC_SAMPLE) && !same;

    always_comb
    begin
        if (func == FUNC_CLOSE)
        begin
            run_count = repeat_count_reg;
        end
        else if (same)
        begin
            run_count = frame_end ? repeat_inc : 8'd0;
        end
        else
        begin
            run_count = repeat_count_reg;
        end
    end

    assign run_gamma  = gamma_code(run_count);
    assign diff_gamma = gamma_code(mag);

    always_comb
    begin
        if (run_count != 8'd0)
        begin
            run_val = ({16'd0, RUN_PREFIX} << run_gamma.len) | {2'b00, run_gamma.code};
            run_len = run_gamma.len + 5'd2;
        end
        else
        begin
            run_val = 18'd0;
            run_len = 5'd0;
        end
        if (emit_diff)
        begin
            diff_val = ({16'd0, is_neg} << diff_gamma.len) | {1'b0, diff_gamma.code};
            diff_len = diff_gamma.len + 5'd1;
        end
        else
        begin
            diff_val = 17'd0;
            diff_len = 5'd0;
        end
    end

    assign acc_a = (ACC_W'(pending_bits_reg) << run_len) | ACC_W'(run_val);
    assign acc_b = (acc_a << diff_len) | ACC_W'(diff_val);
    assign total = 6'(pending_cnt_reg) + 6'(run_len) + 6'(diff_len);
    assign rem   = total[2:0];
    assign pad   = (func == FUNC_CLOSE) && (rem != 3'd0);

    // close pads the last partial byte with zeros, a sample keeps it pending
    assign acc_out = pad ? (acc_b << (4'd8 - {1'b0, rem})) : (acc_b >> rem);

    always_comb
    begin
        if (codec_mode == MODE_RAW)
        begin
            entry.data  = {{(DATA_W - 8){1'b0}}, sample};
            entry.count = (func == FUNC_SAMPLE) ? 3'd1 : 3'd0;
        end
        else
        begin
            entry.data  = acc_out[DATA_W-1:0];
            entry.count = total[5:3] + {2'b00, pad};
        end
    end

    assign push.valid = accept && (entry.count != 3'd0);
    assign push.entry = entry;

    always_comb
    begin
        prev_sample_next  = prev_sample_reg;
        last_diff_next    = last_diff_reg;
        repeat_count_next = repeat_count_reg;
        pending_bits_next = pending_bits_reg;
        pending_cnt_next  = pending_cnt_reg;
        frame_pos_next    = frame_pos_reg;
        if (accept)
        begin
            if (func == FUNC_CLOSE)
            begin
                prev_sample_next  = 8'd0;
                last_diff_next    = 9'd0;
                repeat_count_next = 8'd0;
                pending_bits_next = 7'd0;
                pending_cnt_next  = 3'd0;
                frame_pos_next    = 8'd0;
            end
            else if (codec_mode == MODE_CODER)
            begin
                prev_sample_next  = frame_end ? 8'd0 : sample;
                frame_pos_next    = frame_end ? 8'd0 : frame_inc[7:0];
                pending_bits_next = acc_b[6:0] & ~(7'h7f << rem);
                pending_cnt_next  = rem;
                if (same)
                begin
                    repeat_count_next = frame_end ? 8'd0 : repeat_inc;
                    last_diff_next    = frame_end ? 9'd0 : last_diff_reg;
                end
                else
                begin
                    repeat_count_next = 8'd0;
                    last_diff_next    = frame_end ? 9'd0 : diff;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg  <= 8'd0;
            last_diff_reg    <= 9'd0;
            repeat_count_reg <= 8'd0;
            pending_bits_reg <= 7'd0;
            pending_cnt_reg  <= 3'd0;
            frame_pos_reg    <= 8'd0;
        end
        else
        begin
            prev_sample_reg  <= prev_sample_next;
            last_diff_reg    <= last_diff_next;
            repeat_count_reg <= repeat_count_next;
            pending_bits_reg <= pending_bits_next;
            pending_cnt_reg  <= pending_cnt_next;
            frame_pos_reg    <= frame_pos_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_CLOSE) |=> (pending_cnt_reg == 3'd0))
        else $error("pending bits left after close");

    assert property (@(posedge clk) disable iff (!rst_n)
        frame_pos_reg < FRAME_LENGTH)
        else $error("frame position past frame length");

endmodule

// ===== design/dgr_queue.sv =====
// short queue of packed byte groups between front and back
module dgr_queue
    import dgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dgr_push_t  push,
    output logic       full,
    output logic       empty,
    output dgr_entry_t head,
    input  logic       pop
);

    dgr_entry_t             slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("item pushed into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

endmodule

// ===== design/dgr_back.sv =====
// back: sends each byte group a byte per cycle unless stalled, flags last byte
module dgr_back
    import dgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       queue_empty,
    input  dgr_entry_t head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic [DATA_W-1:0] cur_data_reg;
    logic [2:0]        cur_cnt_reg, cur_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg;
    logic              last_reg;
    logic              advance;
    logic [7:0]        sel_byte;

    assign advance = (cur_cnt_reg != 3'd0) && (!out_valid_reg || out_ready);
    assign pop     = !queue_empty
                     && ((cur_cnt_reg == 3'd0) || ((cur_cnt_reg == 3'd1) && advance));

    always_comb
    begin
        case (cur_cnt_reg)
            3'd1:    sel_byte = cur_data_reg[7:0];
            3'd2:    sel_byte = cur_data_reg[15:8];
            3'd3:    sel_byte = cur_data_reg[23:16];
            3'd4:    sel_byte = cur_data_reg[31:24];
            3'd5:    sel_byte = cur_data_reg[39:32];
            default: sel_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        cur_cnt_next   = cur_cnt_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            cur_cnt_next = head.count;
        end
        else if (advance)
        begin
            cur_cnt_next = cur_cnt_reg - 3'd1;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_cnt_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_cnt_reg   <= cur_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_data_reg <= head.data;
        end
        if (advance)
        begin
            out_byte_reg <= sel_byte;
            last_reg     <= (cur_cnt_reg == 3'd1);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (head.count != 3'd0))
        else $error("empty byte group in queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        cur_cnt_reg <= 3'(MAX_BYTES))
        else $error("byte group longer than five bytes");

endmodule

// ===== design/delta_gamma_rle_audio_encoder.sv =====
// top level of the delta gamma run-length audio coder with its mode register
// Takes one 8-bit sample or a close item per handshake. With codec_mode 0 each sample
// comes back as one byte and a close gives nothing; with codec_mode 1 samples are delta
// coded with run lengths and a gamma-style code (n ones, a zero, the n-1 bits below the
// leading one; zero codes as a single 0), packed MSB first, and a close flushes the run
// and pads the last byte with zeros. The front accepts an item every cycle while its
// two-entry queue has room; the back sends one byte per cycle while out_ready is high,
// and as an item makes 0 to 5 bytes the byte serializer sets the sustained rate. Each
// byte is registered on output. Write codec_mode only while no bytes are outstanding.
module delta_gamma_rle_audio_encoder
    import dgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] sample,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic       codec_mode_reg;
    dgr_push_t  push;
    logic       queue_full;
    logic       queue_empty;
    dgr_entry_t head;
    logic       pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_mode_reg <= MODE_RAW;
        end
        else if (cfg_valid)
        begin
            codec_mode_reg <= cfg_data;
        end
    end

    dgr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .codec_mode (codec_mode_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .sample     (sample),
        .queue_full (queue_full),
        .push       (push)
    );

    dgr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .empty (queue_empty),
        .head  (head),
        .pop   (pop)
    );

    dgr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule
